// ===== design/minmax_feature_normalizer_defines.svh =====
// Assertion macros for the checker file of the normaliser.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef MINMAX_FEATURE_NORMALIZER_DEFINES_SVH
`define MINMAX_FEATURE_NORMALIZER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define MMFN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MMFN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mmfn_pkg.sv =====
`default_nettype none

package mmfn_pkg;

    // Default sizes of the value store, the dimension table and the samples.
    localparam int MAX_VALUES_DEF  = 1024;
    localparam int MAX_DIMS_DEF    = 16;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed widths of the ports.
    localparam int SAMPLE_PORT_BITS = 16;
    localparam int NORM_BITS        = 16;
    localparam int DIM_IDX_BITS     = 4;
    localparam int CFG_BITS         = 5;

    // Request kinds on the input channel.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    // Status codes on the output channel.
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

endpackage

`default_nettype wire

// ===== design/mmfn_ram.sv =====
`default_nettype none

module mmfn_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/mmfn_div.sv =====
`default_nettype none

module mmfn_div
    import mmfn_pkg::*;
#(
    parameter int OP_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [OP_BITS-1:0]   dividend,
    input  wire logic [OP_BITS-1:0]   divisor,
    output logic                      done,
    output logic      [NORM_BITS-1:0] quotient
);

    // The dividend is below the divisor, so the quotient is a pure fraction
    // and one quotient bit is produced per cycle by restoring division.
    localparam int CNT_W = $clog2(NORM_BITS + 1);

    logic                 busy_reg, busy_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [OP_BITS-1:0]   rem_reg;
    logic [OP_BITS-1:0]   div_reg;
    logic [NORM_BITS-1:0] quo_reg;

    logic [OP_BITS:0]     rem_sh;
    logic [OP_BITS:0]     rem_diff;
    logic                 rem_ge;
    logic [OP_BITS-1:0]   rem_step;
    logic                 stepping;

    // One trial subtraction of the shifted remainder.
    always_comb
    begin
        rem_sh   = {rem_reg, 1'b0};
        rem_diff = rem_sh - {1'b0, div_reg};
        rem_ge   = rem_sh >= {1'b0, div_reg};
        rem_step = rem_ge ? rem_diff[OP_BITS-1:0] : rem_sh[OP_BITS-1:0];
    end

    assign stepping = busy_reg && (cnt_reg != '0);
    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = quo_reg;

    // Step counter and busy flag.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NORM_BITS);
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (stepping)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            div_reg <= divisor;
            quo_reg <= '0;
        end
        else if (stepping)
        begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[NORM_BITS-2:0], rem_ge};
        end
    end

endmodule

`default_nettype wire

// ===== design/minmax_feature_normalizer.sv =====
// Min-max feature normaliser. Load beats (req_type 0) store one signed sample
// each, in order, into a value memory of MAX_VALUES entries and fold it into
// the running minimum and maximum of its dimension; dimensions cycle from 0
// to num_dims-1, and loads beyond the capacity are dropped. Fetch beats
// (req_type 1) return the stored values in load order, each scaled to an
// unsigned Q0.16 fraction (value-min)/(max-min) with the minimum and maximum
// as they stand at that moment; a flat dimension gives 0, and a fetch with
// nothing left returns status 1. The user must write num_dims through cfg_we
// and cfg_wdata only while the block is idle; the block does not enforce it.
// Items are handled one at a time: a load reads the per-dimension minimum and
// maximum, then writes them back; an empty fetch goes straight to its result,
// one needing no division reads its value and bounds first, and any other runs
// the 16-step radix-2 divider too. A fetch result waits in its register only
// while the previous result is still held on the output port. The min-max
// table has a valid bit per dimension, so no clearing pass follows reset.
`default_nettype none

module minmax_feature_normalizer
    import mmfn_pkg::*;
#(
    parameter int MAX_VALUES  = MAX_VALUES_DEF,
    parameter int MAX_DIMS    = MAX_DIMS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               req_type,
    input  wire logic signed [SAMPLE_PORT_BITS-1:0] sample,
    input  wire logic                               cfg_we,
    input  wire logic        [CFG_BITS-1:0]         cfg_wdata,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic             [NORM_BITS-1:0]        norm_value,
    output logic             [DIM_IDX_BITS-1:0]     dim_index,
    output logic                                    last_value,
    output logic                                    status
);

    localparam int AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int CW = $clog2(MAX_VALUES + 1);
    localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int S  = SAMPLE_BITS;

    localparam logic signed [S-1:0] VAL_TOP = {1'b0, {(S - 1){1'b1}}};
    localparam logic signed [S-1:0] VAL_BOT = {1'b1, {(S - 1){1'b0}}};

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_LOAD_WB = 3'd1;
    localparam logic [2:0] ST_FETCH   = 3'd2;
    localparam logic [2:0] ST_DIVIDE  = 3'd3;
    localparam logic [2:0] ST_RESULT  = 3'd4;

    // Control state.
    logic [2:0]          state_reg, state_next;
    logic [CFG_BITS-1:0] num_dims_reg, num_dims_next;
    logic [CW-1:0]       load_count_reg, load_count_next;
    logic [CW-1:0]       fetch_count_reg, fetch_count_next;
    logic [DW-1:0]       load_dim_reg, load_dim_next;
    logic [DW-1:0]       fetch_dim_reg, fetch_dim_next;
    logic [MAX_DIMS-1:0] mm_valid_reg, mm_valid_next;
    logic                out_valid_reg, out_valid_next;

    // Payload held across the steps of one item.
    logic [DW-1:0]           cur_dim_reg;
    logic signed [S-1:0]     smp_reg;
    logic                    mm_hit_reg;
    logic [NORM_BITS-1:0]    res_norm_reg;
    logic [DW-1:0]           res_dim_reg;
    logic                    res_last_reg;
    logic                    res_status_reg;
    logic [NORM_BITS-1:0]    out_norm_reg;
    logic [DIM_IDX_BITS-1:0] out_dim_reg;
    logic                    out_last_reg;
    logic                    out_status_reg;

    logic                accept;
    logic                is_load;
    logic                store_full;
    logic                store_empty;
    logic                out_free;
    logic [DW:0]         eff_dims;
    logic [DW:0]         ld_inc;
    logic [DW-1:0]       ld_wrap;
    logic [DW-1:0]       ft_dim;
    logic [DW:0]         ft_inc;
    logic [DW-1:0]       ft_wrap;
    logic signed [31:0]  smp_wide;
    logic signed [S-1:0] smp_in;

    logic                vs_we;
    logic                vs_re;
    logic [S-1:0]        vs_rdata;
    logic                mm_we;
    logic                mm_re;
    logic [DW-1:0]       mm_raddr;
    logic [2*S-1:0]      mm_wdata;
    logic [2*S-1:0]      mm_rdata;

    logic signed [S-1:0] cur_lo;
    logic signed [S-1:0] cur_hi;
    logic signed [S-1:0] fetch_val;
    logic signed [S-1:0] new_lo;
    logic signed [S-1:0] new_hi;
    logic signed [S:0]   span_full;
    logic signed [S:0]   offs_full;
    logic                scale_zero;
    logic                scale_full;
    logic                div_start;
    logic                div_done;
    logic [NORM_BITS-1:0] div_quo;

    // Handshake and occupancy.
    assign in_stall    = state_reg != ST_IDLE;
    assign accept      = in_valid && !in_stall;
    assign is_load     = req_type == REQ_LOAD;
    assign store_full  = load_count_reg >= CW'(MAX_VALUES);
    assign store_empty = fetch_count_reg >= load_count_reg;
    assign out_free    = !out_valid_reg || !out_stall;

    // Effective dimension count: zero acts as one, large values are capped.
    always_comb
    begin
        if (num_dims_reg == '0)
        begin
            eff_dims = (DW + 1)'(1);
        end
        else if (32'(num_dims_reg) > MAX_DIMS)
        begin
            eff_dims = (DW + 1)'(MAX_DIMS);
        end
        else
        begin
            eff_dims = (DW + 1)'(num_dims_reg);
        end
    end

    // Dimension stepping for loads and fetches. The load counter never
    // leaves the table, so only the fetch counter needs the range fold.
    always_comb
    begin
        ld_inc  = {1'b0, load_dim_reg} + 1'b1;
        ld_wrap = (ld_inc >= eff_dims) ? '0 : ld_inc[DW-1:0];
        ft_dim  = ({1'b0, fetch_dim_reg} >= eff_dims) ? '0 : fetch_dim_reg;
        ft_inc  = {1'b0, ft_dim} + 1'b1;
        ft_wrap = (ft_inc >= eff_dims) ? '0 : ft_inc[DW-1:0];
    end

    // Low SAMPLE_BITS bits of the sample, sign-extended.
    assign smp_wide = 32'(sample);
    assign smp_in   = smp_wide[S-1:0];

    // Value store: written on the load beat, read on the fetch beat.
    assign vs_we = accept && is_load && !store_full;
    assign vs_re = accept && !is_load && !store_empty;

    mmfn_ram #(
        .WIDTH (S),
        .DEPTH (MAX_VALUES)
    ) u_value_ram (
        .clk   (clk),
        .we    (vs_we),
        .waddr (load_count_reg[AW-1:0]),
        .wdata (smp_in),
        .re    (vs_re),
        .raddr (fetch_count_reg[AW-1:0]),
        .rdata (vs_rdata)
    );

    // Minimum and maximum table: read on the beat, written back in the next cycle for loads.
    assign mm_re    = vs_we || vs_re;
    assign mm_raddr = is_load ? load_dim_reg : ft_dim;
    assign mm_we    = state_reg == ST_LOAD_WB;
    assign mm_wdata = {new_hi, new_lo};

    mmfn_ram #(
        .WIDTH (2 * S),
        .DEPTH (MAX_DIMS)
    ) u_minmax_ram (
        .clk   (clk),
        .we    (mm_we),
        .waddr (cur_dim_reg),
        .wdata (mm_wdata),
        .re    (mm_re),
        .raddr (mm_raddr),
        .rdata (mm_rdata)
    );

    // An entry never written reads as its reset pair.
    always_comb
    begin
        cur_lo    = mm_hit_reg ? mm_rdata[S-1:0]   : VAL_TOP;
        cur_hi    = mm_hit_reg ? mm_rdata[2*S-1:S] : VAL_BOT;
        fetch_val = vs_rdata;
        new_lo    = (smp_reg < cur_lo) ? smp_reg : cur_lo;
        new_hi    = (smp_reg > cur_hi) ? smp_reg : cur_hi;
    end

    // Scaling: clamp cases first, otherwise divide offset by span.
    always_comb
    begin
        span_full  = {cur_hi[S-1], cur_hi} - {cur_lo[S-1], cur_lo};
        offs_full  = {fetch_val[S-1], fetch_val} - {cur_lo[S-1], cur_lo};
        scale_zero = (cur_hi <= cur_lo) || (fetch_val <= cur_lo);
        scale_full = fetch_val >= cur_hi;
    end

    mmfn_div #(
        .OP_BITS (S)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (offs_full[S-1:0]),
        .divisor  (span_full[S-1:0]),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Sequencer for one item at a time.
    always_comb
    begin
        state_next       = state_reg;
        num_dims_next    = num_dims_reg;
        load_count_next  = load_count_reg;
        fetch_count_next = fetch_count_reg;
        load_dim_next    = load_dim_reg;
        fetch_dim_next   = fetch_dim_reg;
        mm_valid_next    = mm_valid_reg;
        out_valid_next   = out_valid_reg;
        div_start        = 1'b0;

        if (cfg_we)
        begin
            num_dims_next = cfg_wdata;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_load)
                    begin
                        if (!store_full)
                        begin
                            load_count_next = load_count_reg + 1'b1;
                            load_dim_next   = ld_wrap;
                            state_next      = ST_LOAD_WB;
                        end
                    end
                    else if (store_empty)
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        fetch_count_next = fetch_count_reg + 1'b1;
                        fetch_dim_next   = ft_wrap;
                        state_next       = ST_FETCH;
                    end
                end
            end
            ST_LOAD_WB:
            begin
                mm_valid_next[cur_dim_reg] = 1'b1;
                state_next                 = ST_IDLE;
            end
            ST_FETCH:
            begin
                if (scale_zero || scale_full)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            num_dims_reg    <= CFG_BITS'(1);
            load_count_reg  <= '0;
            fetch_count_reg <= '0;
            load_dim_reg    <= '0;
            fetch_dim_reg   <= '0;
            mm_valid_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            num_dims_reg    <= num_dims_next;
            load_count_reg  <= load_count_next;
            fetch_count_reg <= fetch_count_next;
            load_dim_reg    <= load_dim_next;
            fetch_dim_reg   <= fetch_dim_next;
            mm_valid_reg    <= mm_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Item payload and result registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_dim_reg    <= mm_raddr;
            smp_reg        <= smp_in;
            mm_hit_reg     <= mm_valid_reg[mm_raddr];
            res_norm_reg   <= '0;
            res_dim_reg    <= store_empty ? '0 : ft_dim;
            res_last_reg   <= !store_empty && ((fetch_count_reg + 1'b1) == load_count_reg);
            res_status_reg <= store_empty ? STATUS_EMPTY : STATUS_OK;
        end
        if ((state_reg == ST_FETCH) && scale_full && !scale_zero)
        begin
            res_norm_reg <= '1;
        end
        if ((state_reg == ST_DIVIDE) && div_done)
        begin
            res_norm_reg <= div_quo;
        end
        if ((state_reg == ST_RESULT) && out_free)
        begin
            out_norm_reg   <= res_norm_reg;
            out_dim_reg    <= DIM_IDX_BITS'(res_dim_reg);
            out_last_reg   <= res_last_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign norm_value = out_norm_reg;
    assign dim_index  = out_dim_reg;
    assign last_value = out_last_reg;
    assign status     = out_status_reg;

endmodule

`default_nettype wire

// ===== design/mmfn_checker.sv =====
`default_nettype none

`include "minmax_feature_normalizer_defines.svh"

module mmfn_checker
    import mmfn_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_stall,
    input wire logic                    req_type,
    input wire logic                    out_valid,
    input wire logic                    out_stall,
    input wire logic [NORM_BITS-1:0]    norm_value,
    input wire logic [DIM_IDX_BITS-1:0] dim_index,
    input wire logic                    last_value,
    input wire logic                    status
);

    // A stalled result beat keeps its valid and its payload.
    `MMFN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(norm_value) && $stable(dim_index) && $stable(last_value) && $stable(status), "stalled result beat changed")

    // A fetch with nothing left carries an all-zero payload.
    `MMFN_ASSERT_NOW(a_empty_payload, out_valid && (status == STATUS_EMPTY), (norm_value == '0) && (dim_index == '0) && !last_value, "empty fetch result carries data")

    // A fetch occupies the block for at least the following cycle.
    `MMFN_ASSERT_NEXT(a_fetch_busy, in_valid && !in_stall && (req_type == REQ_FETCH), in_stall, "input taken straight after a fetch beat")

endmodule

bind minmax_feature_normalizer mmfn_checker u_mmfn_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .norm_value (norm_value),
    .dim_index  (dim_index),
    .last_value (last_value),
    .status     (status)
);

`default_nettype wire
